// File: rtl/sdop_pkg.sv
// Shared types, constants and helpers for the smoothed orbit camera block.
// Used by the channel interfaces, the divider, the CORDIC unit and the top level.
`default_nettype none
package sdop_pkg;

    // Fixed-point format of all state and ports, and default CORDIC length
    localparam int FRAC_BITS         = 16;
    localparam int CORDIC_STEPS_DFLT = 16;

    localparam logic signed [31:0] ONE_Q  = 32'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [31:0] DIST_RST = 32'(64'sd3 <<< FRAC_BITS);
    localparam logic signed [31:0] C_048  =
        32'(((64'sd48 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
    localparam logic signed [31:0] C_0235 =
        32'(((64'sd235 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);
    localparam logic signed [31:0] PITCH_LIM =
        32'((64'sd13962634016 * (64'sd1 <<< FRAC_BITS) + 64'sd5000000000)
            / 64'sd10000000000);

    // Time step alignment from Q0.16 to FRAC_BITS
    localparam int DT_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DT_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    // Divider: 2^(2F+1)/smooth_time and 2^(2F)/den
    localparam int DIV_NW = 2 * FRAC_BITS + 2;
    localparam logic [DIV_NW-1:0] OMEGA_NUM = DIV_NW'(1) << (2 * FRAC_BITS + 1);
    localparam logic [DIV_NW-1:0] EX_NUM    = DIV_NW'(1) << (2 * FRAC_BITS);

    // CORDIC constants in Q30
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;

    localparam logic [1:0] CFG_SMOOTH = 2'd0;
    localparam logic [1:0] CFG_TGT_X  = 2'd1;
    localparam logic [1:0] CFG_TGT_Y  = 2'd2;
    localparam logic [1:0] CFG_TGT_Z  = 2'd3;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_INPUT     = 2'd1,
        CMD_SET_DIST  = 2'd2,
        CMD_SET_ANGLE = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CMD, ST_DIV_OM, ST_POLY, ST_DIV_EX,
        ST_AXIS, ST_COR_P, ST_COR_Y, ST_POS, ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        CS_IDLE, CS_RED, CS_FOLD, CS_ROT
    } t_cstate;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        delta_time;
        logic signed [31:0] yaw_value;
        logic signed [31:0] pitch_value;
        logic signed [31:0] zoom_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] cur_yaw;
        logic signed [31:0] cur_pitch;
        logic signed [31:0] cur_distance;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [30:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic               start;
        logic signed [31:0] angle;
    } t_cor_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] sin_v;
        logic signed [31:0] cos_v;
    } t_cor_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    // arctan(2^-i) in Q30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0:    return 30'd843314857;
            5'd1:    return 30'd497837829;
            5'd2:    return 30'd263043837;
            5'd3:    return 30'd133525159;
            5'd4:    return 30'd67021687;
            5'd5:    return 30'd33543516;
            5'd6:    return 30'd16775851;
            5'd7:    return 30'd8388437;
            5'd8:    return 30'd4194283;
            5'd9:    return 30'd2097149;
            5'd10:   return 30'd1048576;
            5'd11:   return 30'd524288;
            5'd12:   return 30'd262144;
            5'd13:   return 30'd131072;
            5'd14:   return 30'd65536;
            5'd15:   return 30'd32768;
            5'd16:   return 30'd16384;
            5'd17:   return 30'd8192;
            5'd18:   return 30'd4096;
            5'd19:   return 30'd2048;
            5'd20:   return 30'd1024;
            5'd21:   return 30'd512;
            5'd22:   return 30'd256;
            default: return 30'd128;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: rtl/sdop_if.sv
// Valid/ready channel interfaces for command and result transactions.
// Depends on sdop_pkg for the payload structs.
`default_nettype none
interface sdop_in_if import sdop_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sdop_out_if import sdop_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/smooth_damped_orbit_position.sv
// Smoothed orbit camera: yaw, pitch and distance follow their goals by a
// critically damped step, and the camera position orbits a configured centre.
// Commands arrive on i_in, one result per command leaves on o_out; config
// registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write them only while idle; the block itself does not enforce it.
// i_in.ready is high only while the sequencer is idle: one command at a time.
// A tick runs on one shared 32x32 multiplier (25 products), the radix-2
// divider (used twice, for omega and the exp factor) and the CORDIC unit
// (used for pitch then yaw).
// Results sit in an output register: a stalled receiver holds the result and
// the block may take and work on the next command meanwhile, holding its own
// result back until the register is free.
// Synchronous active-low reset restores distance 3.0, zero angles and rates,
// position (0, 0, 3.0), smooth time 6554 and a zero orbit centre.
// Depends on sdop_pkg, sdop_if, sdop_div and sdop_cordic.
`default_nettype none
module smooth_damped_orbit_position import sdop_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DFLT
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data,
    sdop_in_if.sink     i_in,
    sdop_out_if.source  o_out
);
    t_state             r_state, n_state;
    logic [2:0]         r_sub, n_sub;
    logic [1:0]         r_axis, n_axis;
    logic               r_wb, n_wb;

    // configuration
    logic [30:0]        r_smooth;
    logic signed [31:0] r_tx, r_ty, r_tz;

    // architectural state: index 0 yaw, 1 pitch, 2 distance
    logic signed [31:0] r_cur  [3];
    logic signed [31:0] r_goal [3];
    logic signed [31:0] r_rate [3];
    logic signed [31:0] r_pos  [3];

    // latched command
    t_cmd               r_cmd;
    logic signed [31:0] r_dt, r_yv, r_pv, r_zv;

    // scratch for the tick
    logic signed [31:0] r_omega, r_ex, r_x, r_x2, r_x3, r_t1, r_tmp;
    logic signed [31:0] r_sp, r_cp, r_sy, r_cy;
    logic signed [63:0] r_prod;

    logic               r_out_valid;
    t_out_item          r_out;

    logic               in_fire;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    t_cor_req           cor_req;
    t_cor_rsp           cor_rsp;

    logic signed [31:0] cur_a, goal_a, rate_a, change_c, mq, cur_new;
    logic signed [31:0] op_a, op_b;
    logic signed [34:0] den_c;
    logic [30:0]        den_q;
    logic signed [31:0] quo_sat;
    logic signed [31:0] cmd_yg, cmd_pg, cmd_dg;
    logic [31:0]        dt_conv;

    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign dt_conv    = (32'(i_in.data.delta_time) << DT_L) >> DT_R;

    sdop_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    sdop_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    // axis being stepped
    always_comb begin
        case (r_axis)
            2'd0: begin
                cur_a  = r_cur[0];
                goal_a = r_goal[0];
                rate_a = r_rate[0];
            end
            2'd1: begin
                cur_a  = r_cur[1];
                goal_a = r_goal[1];
                rate_a = r_rate[1];
            end
            default: begin
                cur_a  = r_cur[2];
                goal_a = r_goal[2];
                rate_a = r_rate[2];
            end
        endcase
    end

    always_comb begin
        change_c = sat32(64'(cur_a) - 64'(goal_a));
        mq       = sat32(r_prod >>> FRAC_BITS);
        cur_new  = sat32(64'(goal_a) + 64'(mq));
        // pitch clamp lands with the pitch update itself
        if (r_axis == 2'd1) begin
            if (cur_new > PITCH_LIM) begin
                cur_new = PITCH_LIM;
            end else if (cur_new < -PITCH_LIM) begin
                cur_new = -PITCH_LIM;
            end
        end
        den_c = 35'(ONE_Q) + 35'(r_x) + 35'(r_t1) + 35'(mq);
        if (den_c > 35'sd2147483647) begin
            den_q = 31'h7fffffff;
        end else if (den_c < 35'sd1) begin
            den_q = 31'd1;
        end else begin
            den_q = den_c[30:0];
        end
        quo_sat = sat32($signed(64'(div_rsp.quotient)));
    end

    // input command: goals move by 1.5x angle deltas and 5x zoom delta
    always_comb begin
        cmd_yg = sat32(64'(r_goal[0])
            + 64'(sat32((64'(r_yv) + (64'(r_yv) <<< 1)) >>> 1)));
        cmd_pg = sat32(64'(r_goal[1])
            + 64'(sat32((64'(r_pv) + (64'(r_pv) <<< 1)) >>> 1)));
        cmd_dg = sat32(64'(r_goal[2])
            + 64'(sat32(64'(r_zv) + (64'(r_zv) <<< 2))));
        if (cmd_dg < ONE_Q) begin
            cmd_dg = ONE_Q;
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        op_a = r_omega;
        op_b = r_dt;
        case (r_state)
            ST_POLY: begin
                case (r_sub)
                    3'd0: begin op_a = r_omega; op_b = r_dt; end
                    3'd1: begin op_a = r_x;     op_b = r_x;  end
                    3'd2: begin op_a = r_x2;    op_b = r_x;  end
                    3'd3: begin op_a = C_048;   op_b = r_x2; end
                    default: begin op_a = C_0235; op_b = r_x3; end
                endcase
            end
            ST_AXIS: begin
                case (r_sub)
                    3'd0: begin op_a = r_omega; op_b = change_c; end
                    3'd1: begin
                        op_a = sat32(64'(rate_a) + 64'(r_t1));
                        op_b = r_dt;
                    end
                    3'd2: begin op_a = r_omega; op_b = r_tmp; end
                    3'd3: begin
                        op_a = sat32(64'(rate_a) - 64'(r_t1));
                        op_b = r_ex;
                    end
                    default: begin
                        op_a = sat32(64'(change_c) + 64'(r_tmp));
                        op_b = r_ex;
                    end
                endcase
            end
            ST_POS: begin
                case (r_sub)
                    3'd0: begin op_a = r_cp; op_b = r_cy;     end
                    3'd1: begin op_a = r_t1; op_b = r_cur[2]; end
                    3'd2: begin op_a = r_sp; op_b = r_cur[2]; end
                    3'd3: begin op_a = r_cp; op_b = r_sy;     end
                    default: begin op_a = r_t1; op_b = r_cur[2]; end
                endcase
            end
            default: begin
                op_a = r_omega;
                op_b = r_dt;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state          = r_state;
        n_sub            = r_sub;
        n_axis           = r_axis;
        n_wb             = r_wb;
        div_req.start    = 1'b0;
        div_req.dividend = OMEGA_NUM;
        div_req.divisor  = (r_smooth == '0) ? 31'd1 : r_smooth;
        cor_req.start    = 1'b0;
        cor_req.angle    = (r_state == ST_COR_P) ? r_cur[1] : r_cur[0];
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (t_cmd'(i_in.data.cmd) == CMD_TICK) begin
                        div_req.start = 1'b1;
                        n_state       = ST_DIV_OM;
                    end else begin
                        n_state = ST_CMD;
                    end
                end
            end
            ST_CMD: n_state = ST_OUT;
            ST_DIV_OM: begin
                if (div_rsp.done) begin
                    n_state = ST_POLY;
                    n_sub   = '0;
                    n_wb    = 1'b0;
                end
            end
            ST_POLY: begin
                n_wb = !r_wb;
                if (r_wb) begin
                    if (r_sub == 3'd4) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = EX_NUM;
                        div_req.divisor  = den_q;
                        n_state          = ST_DIV_EX;
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
            end
            ST_DIV_EX: begin
                if (div_rsp.done) begin
                    n_state = ST_AXIS;
                    n_sub   = '0;
                    n_axis  = '0;
                    n_wb    = 1'b0;
                end
            end
            ST_AXIS: begin
                n_wb = !r_wb;
                if (r_wb) begin
                    if (r_sub == 3'd4) begin
                        n_sub = '0;
                        if (r_axis == 2'd2) begin
                            n_state = ST_COR_P;
                        end else begin
                            n_axis = r_axis + 1'b1;
                        end
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
            end
            ST_COR_P, ST_COR_Y: begin
                // first cycle launches the unit, then wait for its result
                if (r_sub == '0) begin
                    cor_req.start = 1'b1;
                    n_sub         = 3'd1;
                end else if (cor_rsp.done) begin
                    n_sub   = '0;
                    n_wb    = 1'b0;
                    n_state = (r_state == ST_COR_P) ? ST_COR_Y : ST_POS;
                end
            end
            ST_POS: begin
                n_wb = !r_wb;
                if (r_wb) begin
                    if (r_sub == 3'd4) begin
                        n_state = ST_OUT;
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sub       <= '0;
            r_axis      <= '0;
            r_wb        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_axis  <= n_axis;
            r_wb    <= n_wb;
            if (r_state == ST_OUT && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration and camera state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth  <= 31'd6554;
            r_tx      <= '0;
            r_ty      <= '0;
            r_tz      <= '0;
            r_cur[0]  <= '0;
            r_cur[1]  <= '0;
            r_cur[2]  <= DIST_RST;
            r_goal[0] <= '0;
            r_goal[1] <= '0;
            r_goal[2] <= DIST_RST;
            r_rate[0] <= '0;
            r_rate[1] <= '0;
            r_rate[2] <= '0;
            r_pos[0]  <= '0;
            r_pos[1]  <= '0;
            r_pos[2]  <= DIST_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SMOOTH: r_smooth <= i_cfg_data[30:0];
                    CFG_TGT_X:  r_tx     <= i_cfg_data;
                    CFG_TGT_Y:  r_ty     <= i_cfg_data;
                    CFG_TGT_Z:  r_tz     <= i_cfg_data;
                    default:    r_tz     <= r_tz;
                endcase
            end
            if (r_state == ST_CMD) begin
                unique case (r_cmd)
                    CMD_INPUT: begin
                        r_goal[0] <= cmd_yg;
                        r_goal[1] <= cmd_pg;
                        r_goal[2] <= cmd_dg;
                    end
                    CMD_SET_DIST: begin
                        r_cur[2]  <= r_zv;
                        r_goal[2] <= r_zv;
                    end
                    CMD_SET_ANGLE: begin
                        r_cur[0]  <= r_yv;
                        r_goal[0] <= r_yv;
                        r_cur[1]  <= r_pv;
                        r_goal[1] <= r_pv;
                    end
                    default: r_cur[0] <= r_cur[0];
                endcase
            end
            if (r_state == ST_AXIS && r_wb) begin
                if (r_sub == 3'd3) begin
                    r_rate[r_axis] <= mq;
                end else if (r_sub == 3'd4) begin
                    r_cur[r_axis] <= cur_new;
                end
            end
            if (r_state == ST_POS && r_wb) begin
                case (r_sub)
                    3'd1: r_pos[0] <= sat32(64'(r_tx) - 64'(mq));
                    3'd2: r_pos[1] <= sat32(64'(r_ty) - 64'(mq));
                    3'd4: r_pos[2] <= sat32(64'(r_tz) - 64'(mq));
                    default: r_pos[0] <= r_pos[0];
                endcase
            end
        end
    end

    // command latch, multiplier and tick scratch
    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        if (in_fire) begin
            r_cmd <= t_cmd'(i_in.data.cmd);
            r_dt  <= dt_conv;
            r_yv  <= i_in.data.yaw_value;
            r_pv  <= i_in.data.pitch_value;
            r_zv  <= i_in.data.zoom_value;
        end
        if (r_state == ST_DIV_OM && div_rsp.done) begin
            r_omega <= quo_sat;
        end
        if (r_state == ST_DIV_EX && div_rsp.done) begin
            r_ex <= quo_sat;
        end
        if (r_state == ST_POLY && r_wb) begin
            case (r_sub)
                3'd0: r_x  <= mq;
                3'd1: r_x2 <= mq;
                3'd2: r_x3 <= mq;
                3'd3: r_t1 <= mq;
                default: r_x <= r_x;
            endcase
        end
        if (r_state == ST_AXIS && r_wb) begin
            case (r_sub)
                3'd0: r_t1  <= mq;
                3'd1: r_tmp <= mq;
                3'd2: r_t1  <= mq;
                default: r_tmp <= r_tmp;
            endcase
        end
        if (r_state == ST_POS && r_wb && (r_sub == 3'd0 || r_sub == 3'd3)) begin
            r_t1 <= mq;
        end
        if (r_state == ST_COR_P && r_sub != '0 && cor_rsp.done) begin
            r_sp <= cor_rsp.sin_v;
            r_cp <= cor_rsp.cos_v;
        end
        if (r_state == ST_COR_Y && r_sub != '0 && cor_rsp.done) begin
            r_sy <= cor_rsp.sin_v;
            r_cy <= cor_rsp.cos_v;
        end
        if (r_state == ST_OUT && (!r_out_valid || o_out.ready)) begin
            r_out.pos_x        <= r_pos[0];
            r_out.pos_y        <= r_pos[1];
            r_out.pos_z        <= r_pos[2];
            r_out.cur_yaw      <= r_cur[0];
            r_out.cur_pitch    <= r_cur[1];
            r_out.cur_distance <= r_cur[2];
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef NO_ASSERTIONS
    // pitch is inside the clamp whenever the position is being formed
    a_pitch_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POS) |-> (r_cur[1] <= PITCH_LIM && r_cur[1] >= -PITCH_LIM))
        else $error("pitch outside clamp during position update");

    // divider only reports while the sequencer waits for it
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV_OM || r_state == ST_DIV_EX))
        else $error("divider result with no waiting step");

    // CORDIC only reports after it was launched by a CORDIC step
    a_cor_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_rsp.done |-> ((r_state == ST_COR_P || r_state == ST_COR_Y) && r_sub != '0))
        else $error("CORDIC result with no waiting step");

    // an input command leaves the distance goal at one or more
    a_dist_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMD && r_cmd == CMD_INPUT) |=> (r_goal[2] >= ONE_Q))
        else $error("distance goal below one after input command");
`endif
endmodule
`default_nettype wire

// File: rtl/sdop_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on sdop_pkg for the request and response structs.
`default_nettype none
module sdop_div import sdop_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CW = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [30:0]       r_rem;
    logic [30:0]       r_dvs;
    logic [DIV_NW-1:0] r_quo;

    logic [31:0]       shifted;
    logic              ge;
    logic [31:0]       diff;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_NW-1]};
        ge      = (shifted >= {1'b0, r_dvs});
        diff    = shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[30:0] : shifted[30:0];
            r_quo <= {r_quo[DIV_NW-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

// File: rtl/sdop_cordic.sv
// Iterative sine/cosine unit: range reduction by shift-subtract, then CORDIC rotation.
// Depends on sdop_pkg for constants, the arctan table and the request structs.
`default_nettype none
module sdop_cordic import sdop_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DFLT
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_cor_req i_req,
    output t_cor_rsp o_rsp
);
    localparam int SH   = 30 - FRAC_BITS;
    localparam int AW   = 62 - FRAC_BITS;
    localparam int KMAX = 29 - FRAC_BITS;
    localparam int KW   = $clog2(KMAX + 1);
    localparam int IW   = $clog2(CORDIC_STEPS);

    localparam logic signed [34:0] K_PI   = 35'(PI_Q30);
    localparam logic signed [34:0] K_2PI  = 35'(TWO_PI_Q30);
    localparam logic signed [34:0] K_HPI  = 35'(HALF_PI_Q30);
    localparam logic [AW-1:0]      K_2PIU = AW'(TWO_PI_Q30);

    t_cstate            r_state, n_state;
    logic [AW-1:0]      r_r, n_r;
    logic [KW-1:0]      r_k, n_k;
    logic               r_neg, n_neg;
    logic               r_negc, n_negc;
    logic signed [32:0] r_a, n_a;
    logic signed [33:0] r_x, n_x;
    logic signed [33:0] r_y, n_y;
    logic [IW-1:0]      r_i, n_i;
    logic               r_done, n_done;
    logic signed [31:0] r_sin, n_sin;
    logic signed [31:0] r_cos, n_cos;

    logic [31:0]        mag;
    logic [AW-1:0]      sub_v;
    logic signed [34:0] a0, a1;
    logic signed [33:0] sx, sy, xf;
    logic signed [32:0] at;

    function automatic logic signed [31:0] from_q30(input logic signed [33:0] v);
        logic signed [35:0] t;
        t = (36'(v) + (36'sd1 <<< (SH - 1))) >>> SH;
        return sat32(64'(t));
    endfunction

    always_comb begin
        n_state = r_state;
        n_r     = r_r;
        n_k     = r_k;
        n_neg   = r_neg;
        n_negc  = r_negc;
        n_a     = r_a;
        n_x     = r_x;
        n_y     = r_y;
        n_i     = r_i;
        n_done  = 1'b0;
        n_sin   = r_sin;
        n_cos   = r_cos;
        mag     = i_req.angle[31] ? (~i_req.angle + 32'd1) : i_req.angle;
        sub_v   = K_2PIU << r_k;
        a0      = r_neg ? -$signed({2'b00, r_r[32:0]}) : $signed({2'b00, r_r[32:0]});
        a1      = a0;
        sx      = r_x >>> r_i;
        sy      = r_y >>> r_i;
        at      = 33'(atan_q30(5'(r_i)));
        xf      = '0;
        unique case (r_state)
            CS_IDLE: begin
                if (i_req.start) begin
                    n_neg   = i_req.angle[31];
                    n_r     = AW'(mag) << SH;
                    n_k     = KW'(KMAX);
                    n_state = CS_RED;
                end
            end
            CS_RED: begin
                // strip multiples of two pi from the magnitude
                if (r_r >= sub_v) begin
                    n_r = r_r - sub_v;
                end
                if (r_k == '0) begin
                    n_state = CS_FOLD;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            CS_FOLD: begin
                if (a0 > K_PI) begin
                    a1 = a0 - K_2PI;
                end else if (a0 < -K_PI) begin
                    a1 = a0 + K_2PI;
                end
                n_negc = 1'b0;
                n_a    = 33'(a1);
                if (a1 > K_HPI) begin
                    n_a    = 33'(K_PI - a1);
                    n_negc = 1'b1;
                end else if (a1 < -K_HPI) begin
                    n_a    = 33'(-K_PI - a1);
                    n_negc = 1'b1;
                end
                n_x     = 34'(GAIN_Q30);
                n_y     = '0;
                n_i     = '0;
                n_state = CS_ROT;
            end
            CS_ROT: begin
                if (!r_a[32]) begin
                    n_x = r_x - sy;
                    n_y = r_y + sx;
                    n_a = r_a - at;
                end else begin
                    n_x = r_x + sy;
                    n_y = r_y - sx;
                    n_a = r_a + at;
                end
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    xf      = r_negc ? -n_x : n_x;
                    n_sin   = from_q30(n_y);
                    n_cos   = from_q30(xf);
                    n_done  = 1'b1;
                    n_state = CS_IDLE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r    <= n_r;
        r_k    <= n_k;
        r_neg  <= n_neg;
        r_negc <= n_negc;
        r_a    <= n_a;
        r_x    <= n_x;
        r_y    <= n_y;
        r_i    <= n_i;
        r_sin  <= n_sin;
        r_cos  <= n_cos;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.sin_v = r_sin;
    assign o_rsp.cos_v = r_cos;
endmodule
`default_nettype wire

// File: tb/sv/tb_smooth_damped_orbit_position.sv
// Self-checking bench for the smoothed orbit camera block: drives commands, predicts
// every result with a cycle-free fixed-point model and compares field by field.
// Depends on sdop_pkg, sdop_if and the block itself.
`default_nettype none
module tb_smooth_damped_orbit_position;
    import sdop_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = CFG_SMOOTH;
    logic [31:0] i_cfg_data = '0;

    sdop_in_if  cmd_ch ();
    sdop_out_if res_ch ();

    smooth_damped_orbit_position DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(cmd_ch.sink), .o_out(res_ch.source)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: a private copy of everything the block keeps
    logic [30:0] m_smooth;
    logic signed [31:0] m_tx, m_ty, m_tz;
    logic signed [31:0] m_yaw, m_pitch, m_dist, m_yaw_g, m_pitch_g, m_dist_g;
    logic signed [31:0] m_yaw_r, m_pitch_r, m_dist_r;
    logic signed [31:0] m_pos [3];

    t_out_item pending_results [$];
    t_out_item last_result;
    int  n_fail = 0;
    int  n_done = 0;
    int  n_ticks = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 1'b0;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Full product, arithmetic shift (floors), then saturate
    function automatic logic signed [31:0] fxmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] q30_to_fx(input longint v);
        int s;
        s = 30 - FRAC_BITS;
        return clamp32((v + (64'sd1 <<< (s - 1))) >>> s);
    endfunction

    function automatic longint atan_entry(input int i);
        longint tab [24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
        return tab[i];
    endfunction

    task automatic sin_cos(input logic signed [31:0] ang,
                           output logic signed [31:0] s_o, output logic signed [31:0] c_o);
        longint a, x, y, t;
        bit flip;
        a = longint'(ang) * (64'sd1 <<< (30 - FRAC_BITS));
        x = GAIN_Q30; y = 0; flip = 0;
        a = a % TWO_PI_Q30;
        if (a > PI_Q30) a -= TWO_PI_Q30;
        if (a < -PI_Q30) a += TWO_PI_Q30;
        if (a > HALF_PI_Q30) begin
            a = PI_Q30 - a; flip = 1;
        end else if (a < -HALF_PI_Q30) begin
            a = -PI_Q30 - a; flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS_DFLT; i++) begin
            if (a >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); x = t; a -= atan_entry(i);
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); x = t; a += atan_entry(i);
            end
        end
        if (flip) x = -x;
        s_o = q30_to_fx(y);
        c_o = q30_to_fx(x);
    endtask

    // One critically damped step of a value toward its goal
    task automatic damp_toward(inout logic signed [31:0] cur, input logic signed [31:0] goal,
                               inout logic signed [31:0] rate,
                               input logic signed [31:0] om, input logic signed [31:0] dt,
                               input logic signed [31:0] ex);
        logic signed [31:0] change, tmp;
        change = clamp32(longint'(cur) - goal);
        tmp = fxmul(clamp32(longint'(rate) + fxmul(om, change)), dt);
        rate = fxmul(clamp32(longint'(rate) - fxmul(om, tmp)), ex);
        cur = clamp32(longint'(goal) + fxmul(clamp32(longint'(change) + tmp), ex));
    endtask

    task automatic model_reset();
        m_smooth = 31'd6554;
        m_tx = 0; m_ty = 0; m_tz = 0;
        m_yaw = 0; m_pitch = 0; m_dist = DIST_RST;
        m_yaw_g = 0; m_pitch_g = 0; m_dist_g = DIST_RST;
        m_yaw_r = 0; m_pitch_r = 0; m_dist_r = 0;
        m_pos[0] = 0; m_pos[1] = 0; m_pos[2] = DIST_RST;
    endtask

    task automatic camera_tick(input logic [15:0] dt_raw);
        longint st, den;
        logic signed [31:0] dt, om, x, x2, x3, ex, sp, cp, sy, cy;
        st = (m_smooth == 0) ? 1 : longint'(m_smooth);
        dt = 32'(longint'(dt_raw) <<< DT_L) >>> DT_R;
        om = clamp32((64'sd2 <<< (2 * FRAC_BITS)) / st);
        x = fxmul(om, dt);
        x2 = fxmul(x, x);
        x3 = fxmul(x2, x);
        den = longint'(ONE_Q) + x + fxmul(C_048, x2) + fxmul(C_0235, x3);
        if (den > 64'sd2147483647) den = 64'sd2147483647;
        if (den < 1) den = 1;
        ex = 32'((longint'(ONE_Q) * ONE_Q) / den);
        damp_toward(m_yaw, m_yaw_g, m_yaw_r, om, dt, ex);
        damp_toward(m_pitch, m_pitch_g, m_pitch_r, om, dt, ex);
        damp_toward(m_dist, m_dist_g, m_dist_r, om, dt, ex);
        if (m_pitch > PITCH_LIM) m_pitch = PITCH_LIM;
        if (m_pitch < -PITCH_LIM) m_pitch = -PITCH_LIM;
        sin_cos(m_pitch, sp, cp);
        sin_cos(m_yaw, sy, cy);
        m_pos[0] = clamp32(longint'(m_tx) - fxmul(fxmul(cp, cy), m_dist));
        m_pos[1] = clamp32(longint'(m_ty) - fxmul(sp, m_dist));
        m_pos[2] = clamp32(longint'(m_tz) - fxmul(fxmul(cp, sy), m_dist));
    endtask

    function automatic t_out_item snapshot();
        t_out_item r;
        r.pos_x = m_pos[0]; r.pos_y = m_pos[1]; r.pos_z = m_pos[2];
        r.cur_yaw = m_yaw; r.cur_pitch = m_pitch; r.cur_distance = m_dist;
        return r;
    endfunction

    task automatic predict_camera(input t_in_item it);
        case (t_cmd'(it.cmd))
            CMD_TICK: begin
                camera_tick(it.delta_time);
                n_ticks++;
            end
            CMD_INPUT: begin
                m_yaw_g = clamp32(longint'(m_yaw_g) + fxmul(it.yaw_value, 3 * ONE_Q / 2));
                m_pitch_g = clamp32(longint'(m_pitch_g) + fxmul(it.pitch_value, 3 * ONE_Q / 2));
                m_dist_g = clamp32(longint'(m_dist_g) + fxmul(it.zoom_value, 5 * ONE_Q));
                if (m_dist_g < ONE_Q) m_dist_g = ONE_Q;
            end
            CMD_SET_DIST: begin
                m_dist = it.zoom_value; m_dist_g = it.zoom_value;
            end
            default: begin
                m_yaw = it.yaw_value; m_pitch = it.pitch_value;
                m_yaw_g = it.yaw_value; m_pitch_g = it.pitch_value;
            end
        endcase
        pending_results.push_back(snapshot());
    endtask

    // Predict on every accepted command transaction
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) predict_camera(cmd_ch.data);
    end

    // Check every accepted result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            last_result = res_ch.data;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: %h", $realtime, res_ch.data);
                n_fail++;
            end else begin
                exp_r = pending_results.pop_front();
                if (res_ch.data !== exp_r) begin
                    $display("%0t: mismatch pos %0d %0d %0d ang %0d %0d dist %0d",
                             $realtime, exp_r.pos_x, exp_r.pos_y, exp_r.pos_z,
                             exp_r.cur_yaw, exp_r.cur_pitch, exp_r.cur_distance);
                    $display("%0t:   actual pos %0d %0d %0d ang %0d %0d dist %0d",
                             $realtime, res_ch.data.pos_x, res_ch.data.pos_y,
                             res_ch.data.pos_z, res_ch.data.cur_yaw,
                             res_ch.data.cur_pitch, res_ch.data.cur_distance);
                    n_fail++;
                end
                n_done++;
            end
        end
    end

    // Receiver: random stall, or a long hold-off when asked
    initial res_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        res_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        int quiet;
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || recv_hold)
            quiet = 0;
        else
            quiet++;
        if (quiet > 20000) begin
            $display("FAIL");
            $finish;
        end
    end

    // Send one command transaction and wait for its acceptance; valid stays
    // high afterwards until the next call idles or drain drops it
    task automatic send_cmd(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= it;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SMOOTH: m_smooth = val[30:0];
            CFG_TGT_X:  m_tx = val;
            CFG_TGT_Y:  m_ty = val;
            default:    m_tz = val;
        endcase
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic t_in_item pick(input logic [1:0] c, input logic [15:0] dt,
                                      input logic [31:0] y, input logic [31:0] p,
                                      input logic [31:0] z);
        t_in_item it;
        it.cmd = c; it.delta_time = dt; it.yaw_value = y; it.pitch_value = p;
        it.zoom_value = z;
        return it;
    endfunction

    // Mostly a playable camera; now and then raw extremes of every field
    function automatic t_in_item random_cmd();
        t_in_item it;
        it = pick(2'($urandom_range(3)), 16'($urandom), $urandom, $urandom, $urandom);
        if ($urandom_range(9) < 8) begin
            it.yaw_value = $signed($urandom_range(200000)) - 100000;
            it.pitch_value = $signed($urandom_range(200000)) - 100000;
            it.zoom_value = (it.cmd == CMD_SET_DIST) ? $urandom_range(1 << 22)
                                                     : $signed($urandom_range(40000)) - 20000;
            if ($urandom_range(1)) it.delta_time = 16'($urandom_range(2000));
        end
        if (it.cmd != CMD_TICK && $urandom_range(1)) it.cmd = CMD_TICK;
        return it;
    endfunction

    typedef struct {
        t_in_item   it;
        bit         known;
        t_out_item  want;
    } t_row;

    initial begin
        t_row rows [$];
        t_out_item rst_view;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        model_reset();
        rst_view = snapshot();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: a zero input straight after reset leaves the reset view
        rows.push_back('{pick(CMD_INPUT, 16'd0, 0, 0, 0), 1, rst_view});
        rows.push_back('{pick(CMD_TICK, 16'd0, 0, 0, 0), 0, rst_view});
        rows.push_back('{pick(CMD_TICK, 16'hffff, 0, 0, 0), 0, rst_view});
        rows.push_back('{pick(CMD_SET_ANGLE, 16'hffff, 32'h7fffffff, 32'h80000000, 0), 0, rst_view});
        rows.push_back('{pick(CMD_TICK, 16'h0100, 0, 0, 0), 0, rst_view});
        rows.push_back('{pick(CMD_SET_ANGLE, 16'd0, 32'h80000000, 32'h7fffffff, 0), 0, rst_view});
        rows.push_back('{pick(CMD_TICK, 16'hffff, 0, 0, 0), 0, rst_view});
        rows.push_back('{pick(CMD_INPUT, 16'd0, 32'h7fffffff, 32'h7fffffff, 32'h80000000), 0, rst_view});
        rows.push_back('{pick(CMD_TICK, 16'h8000, 0, 0, 0), 0, rst_view});
        rows.push_back('{pick(CMD_INPUT, 16'd0, 32'h80000000, 32'h80000000, 32'h7fffffff), 0, rst_view});
        rows.push_back('{pick(CMD_SET_DIST, 16'd0, 0, 0, 32'h80000000), 0, rst_view});
        rows.push_back('{pick(CMD_TICK, 16'h0001, 0, 0, 0), 0, rst_view});
        rows.push_back('{pick(CMD_SET_DIST, 16'd0, 0, 0, 32'h7fffffff), 0, rst_view});
        rows.push_back('{pick(CMD_SET_ANGLE, 16'd0, 32'sd205887, -32'sd102944, 0), 0, rst_view});
        rows.push_back('{pick(CMD_TICK, 16'h4000, 0, 0, 0), 0, rst_view});
        rows.push_back('{pick(CMD_SET_ANGLE, 16'd0, -32'sd411775, 32'sd200000, 0), 0, rst_view});
        rows.push_back('{pick(CMD_TICK, 16'h0800, 0, 0, 0), 0, rst_view});
        foreach (rows[i]) begin
            send_cmd(rows[i].it);
            // Known rows wait for their result and compare it with the table
            if (rows[i].known) begin
                drain();
                if (last_result !== rows[i].want) begin
                    $display("%0t: table row %0d expected %h actual %h",
                             $realtime, i, rows[i].want, last_result);
                    n_fail++;
                end
            end
        end
        drain();

        // Random phases across register settings, extremes among them
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_reg(CFG_SMOOTH, 32'd1);
                1: write_reg(CFG_SMOOTH, 32'h7fffffff);
                2: write_reg(CFG_SMOOTH, 32'h80000000);
                default: write_reg(CFG_SMOOTH, $urandom_range(200000, 1));
            endcase
            write_reg(CFG_TGT_X, ph == 1 ? 32'h7fffffff : $urandom);
            write_reg(CFG_TGT_Y, ph == 1 ? 32'h80000000 : $signed($urandom_range(1 << 20)));
            write_reg(CFG_TGT_Z, ph == 2 ? 32'h80000000 : $urandom);
            if (ph < 2) begin
                send_idle_pct = 30; recv_idle_pct = 73;
            end else if (ph < 4) begin
                send_idle_pct = 73; recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            if (ph == 4) begin
                // Hold the receiver off while commands keep coming
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (2000) @(posedge i_clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            repeat (272) send_cmd(random_cmd());
            drain();
        end

        $display("Covered %0d results (%0d ticks) over six register settings,", n_done, n_ticks);
        $display("with stalls on both sides and one long receiver hold-off.");
        if (n_fail == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
rtl/sdop_pkg.sv
rtl/sdop_if.sv
rtl/sdop_div.sv
rtl/sdop_cordic.sv
rtl/smooth_damped_orbit_position.sv
tb/sv/tb_smooth_damped_orbit_position.sv
